/* sv/pdm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared widths, command codes, sequencer states and the saturating row sum
// adder of the packed distance matrix store.
// ----------------------------------------------------------------------------
package pdm_pkg;

  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_VALUE_BITS = 32;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 9;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;

  localparam logic [CMD_W-1:0] CMD_BEGIN      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_ENTRY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_SUM   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

  localparam logic [CFG_W-1:0] INIT_SIZE_RST = 9'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM_A,
    ST_SUM_B,
    ST_WAIT_READ,
    ST_CLEAR,
    ST_MOVE_SUM,
    ST_WALK,
    ST_DONE
  } state_t;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

/* sv/pdm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_if
// Request, response and configuration channels of the packed distance
// matrix store, each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface pdm_req_if import pdm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface pdm_rsp_if import pdm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  read_value;
  logic                     index_error;
  logic [CFG_W-1:0]         live_rows;

  modport source (output valid, read_value, index_error, live_rows, input ready);
  modport sink   (input valid, read_value, index_error, live_rows, output ready);
endinterface

interface pdm_cfg_if import pdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  initial_size;

  modport source (output valid, initial_size, input ready);
  modport sink   (input valid, initial_size, output ready);
endinterface

/* sv/pdm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/packed_distance_matrix_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_distance_matrix_store
// Symmetric distance matrix kept as a packed lower triangle in one RAM, with
// a second RAM of saturating 48-bit row sums and a live row count.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | taken when
//  req     | in  | command, row, col, value                 | valid && ready
//  rsp     | out | read_value, index_error, live_rows       | valid && ready
//  cfg     | in  | initial_size                             | valid && ready
//
//  set, read, error and unknown requests go from check to done (entry and sum
//  reads through a read wait); load adds two row sum read-modify-writes through
//  the single row sum read port. begin runs a clearing pass, one row sum a cycle.
//  remove row moves the last row sum, then makes one copy per row (last row: none).
//  reset clears the count and control; row sums are valid only after begin.
//  a response waiting on rsp does not stop the next request being taken.
// ----------------------------------------------------------------------------
module packed_distance_matrix_store import pdm_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  pdm_req_if.sink     req,
  pdm_rsp_if.source   rsp,
  pdm_cfg_if.sink     cfg
);

  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS - 1) / 2;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WALK_W      = $clog2(MAX_ROWS + 2);

  function automatic logic [STORE_AW-1:0] slot_of(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
    logic [ROW_W-1:0]   hi;
    logic [ROW_W-1:0]   lo;
    logic [2*ROW_W-1:0] prod;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = {{ROW_W{1'b0}}, hi} * {{ROW_W{1'b0}}, hi - ROW_W'(1)};
    return STORE_AW'((prod >> 1) + {{ROW_W{1'b0}}, lo});
  endfunction

  state_t state, state_next;

  logic [CMD_W-1:0]              cmd_q;
  logic [IDX_W-1:0]              row_q;
  logic [IDX_W-1:0]              col_q;
  logic signed [VALUE_BITS-1:0]  val_q;
  logic [CFG_W-1:0]              live_count, live_count_next;
  logic [CFG_W-1:0]              init_size, init_size_next;
  logic signed [SUM_W-1:0]       res_value, res_value_next;
  logic                          res_err, res_err_next;
  logic [ROW_W-1:0]              clr_ptr, clr_ptr_next;
  logic [WALK_W-1:0]             walk_i, walk_i_next;

  logic                          a_vld, a_vld_next;
  logic                          a_zero, a_zero_next;
  logic [STORE_AW-1:0]           a_ra, a_ra_next;
  logic [STORE_AW-1:0]           a_wa, a_wa_next;
  logic                          b_vld;
  logic                          b_zero;
  logic [STORE_AW-1:0]           b_wa;

  logic                          out_valid, out_valid_next;
  logic signed [SUM_W-1:0]       out_value, out_value_next;
  logic                          out_err, out_err_next;
  logic [CFG_W-1:0]              out_rows, out_rows_next;

  logic                          dist_we;
  logic [STORE_AW-1:0]           dist_waddr;
  logic [VALUE_BITS-1:0]         dist_wdata;
  logic [STORE_AW-1:0]           dist_raddr;
  logic [VALUE_BITS-1:0]         dist_rdata;

  logic                          sum_we;
  logic [ROW_W-1:0]              sum_waddr;
  logic signed [SUM_W-1:0]       sum_wdata;
  logic [ROW_W-1:0]              sum_raddr;
  logic signed [SUM_W-1:0]       sum_rdata;

  logic                          req_take;
  logic                          r_ok;
  logic                          c_ok;
  logic                          pair_live;
  logic                          is_last;
  logic                          out_free;
  logic [ROW_W-1:0]              r_row;
  logic [ROW_W-1:0]              c_row;
  logic [ROW_W-1:0]              i_row;
  logic [WALK_W-1:0]             walk_end;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_value;
  assign rsp.index_error = out_err;
  assign rsp.live_rows   = out_rows;
  assign out_free        = !out_valid || rsp.ready;

  assign r_ok      = ({1'b0, row_q} < live_count);
  assign c_ok      = ({1'b0, col_q} < live_count);
  assign pair_live = r_ok && c_ok;
  assign is_last   = ({1'b0, row_q} == (live_count - CFG_W'(1)));
  assign r_row     = ROW_W'(row_q);
  assign c_row     = ROW_W'(col_q);
  assign i_row     = ROW_W'(walk_i);
  assign walk_end  = WALK_W'(live_count) + WALK_W'(2);

  pdm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  pdm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (cmd_q)
          CMD_BEGIN:      state_next = ST_CLEAR;
          CMD_LOAD:       state_next = (pair_live && row_q != col_q) ? ST_SUM_A : ST_DONE;
          CMD_READ_ENTRY: state_next = (pair_live && row_q != col_q) ? ST_WAIT_READ : ST_DONE;
          CMD_READ_SUM:   state_next = r_ok ? ST_WAIT_READ : ST_DONE;
          CMD_REMOVE:     state_next = (r_ok && !is_last) ? ST_MOVE_SUM : ST_DONE;
          default:        state_next = ST_DONE;
        endcase
      end
      ST_SUM_A:     state_next = ST_SUM_B;
      ST_SUM_B:     state_next = ST_DONE;
      ST_WAIT_READ: state_next = ST_DONE;
      ST_CLEAR: begin
        if (clr_ptr == ROW_W'(MAX_ROWS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_MOVE_SUM:  state_next = ST_WALK;
      ST_WALK: begin
        if (walk_i == walk_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    live_count_next = live_count;
    init_size_next  = cfg.valid ? cfg.initial_size : init_size;
    res_value_next  = res_value;
    res_err_next    = res_err;
    clr_ptr_next    = clr_ptr;
    walk_i_next     = walk_i;

    out_valid_next  = out_valid;
    out_value_next  = out_value;
    out_err_next    = out_err;
    out_rows_next   = out_rows;
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    dist_we    = b_vld;
    dist_waddr = b_wa;
    dist_wdata = b_zero ? '0 : dist_rdata;
    dist_raddr = a_ra;

    sum_we     = 1'b0;
    sum_waddr  = r_row;
    sum_wdata  = '0;
    sum_raddr  = r_row;

    // copy walk: row i takes the entry of the last row into the removed slot
    a_vld_next  = (state == ST_WALK) && (walk_i <= WALK_W'(live_count)) && (i_row != r_row);
    a_zero_next = (i_row == ROW_W'(live_count));
    a_ra_next   = slot_of(i_row, ROW_W'(live_count));
    a_wa_next   = slot_of(i_row, r_row);

    case (state)
      ST_CHECK: begin
        res_value_next = '0;
        res_err_next   = 1'b0;
        dist_raddr     = slot_of(r_row, c_row);
        dist_waddr     = slot_of(r_row, c_row);
        dist_wdata     = val_q;
        dist_we        = 1'b0;
        case (cmd_q)
          CMD_BEGIN: begin
            live_count_next = (init_size > MAX_ROWS) ? CFG_W'(MAX_ROWS) : init_size;
            clr_ptr_next    = '0;
          end
          CMD_LOAD, CMD_SET: begin
            res_err_next = !pair_live;
            dist_we      = pair_live && (row_q != col_q);
          end
          CMD_READ_ENTRY: begin
            res_err_next = !pair_live;
          end
          CMD_READ_SUM: begin
            res_err_next = !r_ok;
          end
          CMD_REMOVE: begin
            res_err_next = !r_ok;
            sum_raddr    = ROW_W'(live_count - CFG_W'(1));
            walk_i_next  = '0;
            if (r_ok) begin
              live_count_next = live_count - CFG_W'(1);
            end
          end
          default: begin
            res_err_next = 1'b0;
          end
        endcase
      end
      ST_SUM_A: begin
        sum_we    = 1'b1;
        sum_waddr = r_row;
        sum_wdata = sat_add(sum_rdata, SUM_W'(val_q));
        sum_raddr = c_row;
      end
      ST_SUM_B: begin
        sum_we    = 1'b1;
        sum_waddr = c_row;
        sum_wdata = sat_add(sum_rdata, SUM_W'(val_q));
      end
      ST_WAIT_READ: begin
        if (cmd_q == CMD_READ_ENTRY) begin
          res_value_next = SUM_W'($signed(dist_rdata));
        end else begin
          res_value_next = sum_rdata;
        end
      end
      ST_CLEAR: begin
        sum_we       = 1'b1;
        sum_waddr    = clr_ptr;
        sum_wdata    = '0;
        clr_ptr_next = clr_ptr + ROW_W'(1);
      end
      ST_MOVE_SUM: begin
        sum_we    = 1'b1;
        sum_waddr = r_row;
        sum_wdata = sum_rdata;
      end
      ST_WALK: begin
        walk_i_next = walk_i + WALK_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_value_next = res_value;
          out_err_next   = res_err;
          out_rows_next  = live_count;
        end
      end
      default: begin
        sum_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live_count <= '0;
      init_size  <= INIT_SIZE_RST;
      out_valid  <= 1'b0;
      a_vld      <= 1'b0;
      b_vld      <= 1'b0;
    end else begin
      state      <= state_next;
      live_count <= live_count_next;
      init_size  <= init_size_next;
      out_valid  <= out_valid_next;
      a_vld      <= a_vld_next;
      b_vld      <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd_q <= req.command;
      row_q <= req.row;
      col_q <= req.col;
      val_q <= VALUE_BITS'(req.value);
    end
    res_value <= res_value_next;
    res_err   <= res_err_next;
    clr_ptr   <= clr_ptr_next;
    walk_i    <= walk_i_next;
    a_zero    <= a_zero_next;
    a_ra      <= a_ra_next;
    a_wa      <= a_wa_next;
    b_zero    <= a_zero;
    b_wa      <= a_wa;
    out_value <= out_value_next;
    out_err   <= out_err_next;
    out_rows  <= out_rows_next;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= MAX_ROWS)
    else $error("live count beyond row capacity");

  a_take_to_check: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == ST_CHECK)
    else $error("request not decoded after acceptance");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.index_error |-> rsp.read_value == '0)
    else $error("flagged response carries a value");

  a_sum_rmw_apart: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM_A |-> sum_waddr != sum_raddr)
    else $error("row sum update collides with its own read");

  a_dist_write_state: assert property (@(posedge clk) disable iff (rst)
    dist_we |-> (state == ST_CHECK || state == ST_WALK))
    else $error("distance write outside an entry request or copy walk");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed distance matrix store. A tracker class
// keeps its own triangle, row sums and live count, predicts the one reply of
// every accepted request and checks the replies in order. The run goes from
// directed corner cases to sessions of filled matrices with random requests,
// under several sender idle and receiver stall mixes and begin sizes.
// ----------------------------------------------------------------------------
module tb;
  import pdm_pkg::*;

  localparam int MAX_ROWS    = DEF_MAX_ROWS;
  localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS - 1) / 2;
  localparam int DENSE_ROWS  = 40;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 300;
  localparam int SESSIONS    = 12;

  localparam longint SUM_TOP = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_BOT = -SUM_TOP - 1;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  typedef struct packed {
    logic signed [SUM_W-1:0] read_value;
    logic                    index_error;
    logic [CFG_W-1:0]        live_rows;
  } reply_t;

  class distance_tracker;
    logic signed [VAL_W-1:0] triangle [STORE_DEPTH];
    bit                      known [STORE_DEPTH];
    logic signed [SUM_W-1:0] sums [MAX_ROWS];
    int                      live;
    logic [CFG_W-1:0]        size_reg;
    reply_t                  expected_replies [$];
    int                      mismatches;
    int                      accepted;
    int                      checked;

    function new();
      live       = 0;
      size_reg   = INIT_SIZE_RST;
      mismatches = 0;
      accepted   = 0;
      checked    = 0;
      foreach (sums[i]) sums[i] = '0;
      foreach (known[i]) known[i] = 1'b0;
    endfunction

    function int slot_of(int a, int b);
      if (b > a) return b * (b - 1) / 2 + a;
      return a * (a - 1) / 2 + b;
    endfunction

    function bit is_known(int a, int b);
      return (a == b) || known[slot_of(a, b)];
    endfunction

    function logic signed [VAL_W-1:0] entry(int a, int b);
      if (a == b) return '0;
      return triangle[slot_of(a, b)];
    endfunction

    function void store(int a, int b, logic signed [VAL_W-1:0] v, bit k);
      if (a == b) return;
      triangle[slot_of(a, b)] = v;
      known[slot_of(a, b)]    = k;
    endfunction

    function logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] acc,
                                                logic signed [VAL_W-1:0] d);
      longint s;
      s = longint'(acc) + longint'(d);
      if (s > SUM_TOP) s = SUM_TOP;
      else if (s < SUM_BOT) s = SUM_BOT;
      return s[SUM_W-1:0];
    endfunction

    // a remove reads every entry of the last row except the removed one
    function bit removal_safe(int r);
      int last;
      int i;
      last = live - 1;
      if (r == last) return 1'b1;
      for (i = 0; i < last; i++)
        if (i != r && !is_known(i, last)) return 1'b0;
      return 1'b1;
    endfunction

    function void take_request(logic [CMD_W-1:0] cmd, int r, int c,
                               logic signed [VAL_W-1:0] v);
      reply_t                  want;
      logic signed [VAL_W-1:0] d;
      int                      last;
      int                      i;
      want = '0;
      accepted++;
      case (cmd)
        CMD_BEGIN: begin
          live = (size_reg > MAX_ROWS) ? MAX_ROWS : int'(size_reg);
          foreach (sums[k]) sums[k] = '0;
        end
        CMD_LOAD, CMD_SET: begin
          if (r >= live || c >= live) begin
            want.index_error = 1'b1;
          end else if (r != c) begin
            store(r, c, v, 1'b1);
            if (cmd == CMD_LOAD) begin
              sums[r] = clamp_add(sums[r], v);
              sums[c] = clamp_add(sums[c], v);
            end
          end
        end
        CMD_READ_ENTRY: begin
          if (r >= live || c >= live) begin
            want.index_error = 1'b1;
          end else begin
            d = entry(r, c);
            want.read_value = {{(SUM_W-VAL_W){d[VAL_W-1]}}, d};
          end
        end
        CMD_READ_SUM: begin
          if (r >= live) want.index_error = 1'b1;
          else want.read_value = sums[r];
        end
        CMD_REMOVE: begin
          if (r >= live) begin
            want.index_error = 1'b1;
          end else begin
            last = live - 1;
            if (r != last) begin
              sums[r] = sums[last];
              for (i = 0; i <= last; i++)
                if (i != r) store(i, r, entry(i, last), is_known(i, last));
            end
            live = last;
          end
        end
        default: ;
      endcase
      want.live_rows = live[CFG_W-1:0];
      expected_replies.push_back(want);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing pending: value %0d error %0b rows %0d",
                 $time, got.read_value, got.index_error, got.live_rows);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d",
                 $time, want.read_value, got.read_value);
        mismatches++;
      end
      if (got.index_error !== want.index_error) begin
        $display("%0t: index_error expected %0b actual %0b",
                 $time, want.index_error, got.index_error);
        mismatches++;
      end
      if (got.live_rows !== want.live_rows) begin
        $display("%0t: live_rows expected %0d actual %0d",
                 $time, want.live_rows, got.live_rows);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pdm_req_if req_ch ();
  pdm_rsp_if rsp_ch ();
  pdm_cfg_if cfg_ch ();

  packed_distance_matrix_store dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  distance_tracker tracker;
  int send_idle    = 0;
  int recv_stall   = 0;
  int quiet_cycles = 0;

  int session_size [SESSIONS] = '{5, 2, 12, 0, 1, 18, 511, 257, 8, 3, 10, 6};
  int session_ops  [SESSIONS] = '{60, 30, 80, 10, 15, 60, 40, 40, 80, 50, 80, 80};

  always #2 clk = ~clk;

  always @(posedge clk) begin
    reply_t got;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.read_value  = rsp_ch.read_value;
        got.index_error = rsp_ch.index_error;
        got.live_rows   = rsp_ch.live_rows;
        tracker.check_reply(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
               $time, quiet_cycles, tracker.expected_replies.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VAL_W-1:0] random_distance();
    case ($urandom_range(9))
      0:       return {1'b0, {(VAL_W-1){1'b1}}};
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      2:       return $urandom_range(32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
                              logic [IDX_W-1:0] c, logic signed [VAL_W-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.row     <= r;
    req_ch.col     <= c;
    req_ch.value   <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.take_request(cmd, int'(r), int'(c), v);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] rows_cfg);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.initial_size <= rows_cfg;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid     <= 1'b0;
    tracker.size_reg = rows_cfg;
  endtask

  // small matrices get every entry, large ones only the last row
  task automatic fill_matrix();
    int n, a, b, j, tmp;
    int pairs [$];
    n = tracker.live;
    if (n <= DENSE_ROWS) begin
      for (a = 1; a < n; a++)
        for (b = 0; b < a; b++) pairs.push_back(a * MAX_ROWS + b);
    end else begin
      for (b = 0; b < n - 1; b++) pairs.push_back((n - 1) * MAX_ROWS + b);
    end
    for (a = pairs.size() - 1; a > 0; a--) begin
      j        = $urandom_range(a);
      tmp      = pairs[a];
      pairs[a] = pairs[j];
      pairs[j] = tmp;
    end
    foreach (pairs[k]) begin
      a = pairs[k] / MAX_ROWS;
      b = pairs[k] % MAX_ROWS;
      if ($urandom_range(1)) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      send_request(($urandom_range(4) == 0) ? CMD_SET : CMD_LOAD,
                   a[IDX_W-1:0], b[IDX_W-1:0], random_distance());
    end
  endtask

  task automatic mixed_request();
    int               live, pick, a, b, tries;
    logic [CMD_W-1:0] cmd;
    live = tracker.live;
    pick = (live == 0) ? $urandom_range(85, 99) : $urandom_range(99);
    a    = (live > 0) ? $urandom_range(live - 1) : 0;
    b    = (live > 0) ? $urandom_range(live - 1) : 0;
    if (pick < 30) begin
      cmd = CMD_LOAD;
    end else if (pick < 40) begin
      cmd = CMD_SET;
    end else if (pick < 65) begin
      cmd   = CMD_READ_ENTRY;
      tries = 0;
      while (!tracker.is_known(a, b) && tries < 8) begin
        a = $urandom_range(live - 1);
        b = $urandom_range(live - 1);
        tries++;
      end
      if (!tracker.is_known(a, b)) b = a;
    end else if (pick < 78) begin
      cmd = CMD_READ_SUM;
    end else if (pick < 85) begin
      cmd = CMD_REMOVE;
      if (!tracker.removal_safe(a)) a = live - 1;
    end else if (pick < 93) begin
      if (live == MAX_ROWS) begin
        cmd = CMD_UNUSED_A;
      end else begin
        case ($urandom_range(4))
          0:       cmd = CMD_LOAD;
          1:       cmd = CMD_SET;
          2:       cmd = CMD_READ_ENTRY;
          3:       cmd = CMD_READ_SUM;
          default: cmd = CMD_REMOVE;
        endcase
        a = $urandom_range(live, MAX_ROWS - 1);
        b = $urandom_range(MAX_ROWS - 1);
        if (live > 0 && cmd != CMD_READ_SUM && cmd != CMD_REMOVE && $urandom_range(1)) begin
          b = a;
          a = $urandom_range(live - 1);
        end
      end
    end else if (pick < 96) begin
      cmd = $urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    end else begin
      cmd = CMD_BEGIN;
    end
    send_request(cmd, a[IDX_W-1:0], b[IDX_W-1:0], random_distance());
  endtask

  task automatic run_session(logic [CFG_W-1:0] rows_cfg, int ops, int mode);
    write_size(rows_cfg);
    case (mode % 4)
      0:       begin send_idle = 0;  recv_stall = 0;  end
      1:       begin send_idle = 56; recv_stall = 0;  end
      2:       begin send_idle = 0;  recv_stall = 56; end
      default: begin send_idle = 7;  recv_stall = 7;  end
    endcase
    send_request(CMD_BEGIN, IDX_W'($urandom_range(255)), IDX_W'($urandom_range(255)),
                 random_distance());
    fill_matrix();
    repeat (ops) begin
      if ($urandom_range(149) == 0) wait_drained();
      mixed_request();
    end
  endtask

  initial begin
    tracker = new();
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_BEGIN;
    req_ch.row          <= '0;
    req_ch.col          <= '0;
    req_ch.value        <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.initial_size <= INIT_SIZE_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // corner cases on the reset size of two rows
    send_request(CMD_UNUSED_A, 8'd0, 8'd0, '0);
    send_request(CMD_READ_SUM, 8'd0, 8'd0, '0);
    send_request(CMD_BEGIN, 8'd0, 8'd0, '0);
    send_request(CMD_LOAD, 8'd1, 8'd0, 32'h7FFF_FFFF);
    send_request(CMD_LOAD, 8'd0, 8'd1, 32'h8000_0000);
    send_request(CMD_READ_ENTRY, 8'd0, 8'd1, '0);
    send_request(CMD_READ_ENTRY, 8'd1, 8'd1, '0);
    send_request(CMD_LOAD, 8'd1, 8'd1, 32'h1234_5678);
    send_request(CMD_SET, 8'd1, 8'd1, 32'h0001_0000);
    send_request(CMD_SET, 8'd0, 8'd1, '1);
    send_request(CMD_READ_ENTRY, 8'd1, 8'd0, '0);
    send_request(CMD_READ_SUM, 8'd0, 8'd0, '0);
    send_request(CMD_READ_SUM, 8'd1, 8'd0, '0);
    send_request(CMD_READ_ENTRY, 8'd2, 8'd0, '0);
    send_request(CMD_LOAD, 8'd0, 8'd255, 32'h0000_0001);
    send_request(CMD_SET, 8'd255, 8'd0, 32'h0000_0001);
    send_request(CMD_READ_SUM, 8'd255, 8'd0, '0);
    send_request(CMD_REMOVE, 8'd2, 8'd0, '0);
    send_request(CMD_UNUSED_B, 8'd255, 8'd255, '1);
    send_request(CMD_REMOVE, 8'd0, 8'd0, '0);
    send_request(CMD_READ_ENTRY, 8'd0, 8'd0, '0);
    send_request(CMD_READ_SUM, 8'd0, 8'd0, '0);
    send_request(CMD_REMOVE, 8'd0, 8'd0, '0);
    send_request(CMD_READ_ENTRY, 8'd0, 8'd0, '0);

    for (int s = 0; s < SESSIONS; s++)
      run_session(CFG_W'(session_size[s]), session_ops[s], s);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d requests and %0d checked replies over %0d sessions",
             tracker.accepted, tracker.checked, SESSIONS);
    $display("begin sizes 0 to 511, fills, removes and range errors under four idle mixes");
    if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d replies never arrived",
               tracker.mismatches, tracker.expected_replies.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
